// ----- rtl/gptr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, register codes and grid helpers for the grid pattern trail recognizer.
// No dependencies; every other file imports this package.
package gptr_pkg;

	localparam int NODE_COUNT = 9;
	localparam int GRID_SIDE  = 3;
	localparam int HALF_W     = 16;
	localparam int RADIUS_W   = 15;
	localparam int RSQ_W      = 2 * RADIUS_W;

	localparam logic [2:0] REG_NODE_A   = 3'd0;
	localparam logic [2:0] REG_NODE_B   = 3'd1;
	localparam logic [2:0] REG_NODE_C   = 3'd2;
	localparam logic [2:0] REG_NODE_D   = 3'd3;
	localparam logic [2:0] REG_NODE_E   = 3'd4;
	localparam logic [2:0] REG_RADIUS   = 3'd5;
	localparam logic [2:0] REG_BOX_LOW  = 3'd6;
	localparam logic [2:0] REG_BOX_HIGH = 3'd7;

	typedef struct packed {
		logic start;
		logic stop;
	} in_ctl_t;

	typedef struct packed {
		logic [3:0] node;
		logic       skip;
		logic       oob;
		logic [3:0] len;
		logic       last;
	} res_t;

	function automatic logic [1:0] node_col(input logic [3:0] n);
		logic [1:0] c;
		unique case (n)
			4'd1, 4'd4, 4'd7: c = 2'd0;
			4'd2, 4'd5, 4'd8: c = 2'd1;
			4'd3, 4'd6, 4'd9: c = 2'd2;
			default:          c = 2'd0;
		endcase
		return c;
	endfunction

	function automatic logic [1:0] node_row(input logic [3:0] n);
		logic [1:0] r;
		unique case (n)
			4'd1, 4'd2, 4'd3: r = 2'd0;
			4'd4, 4'd5, 4'd6: r = 2'd1;
			4'd7, 4'd8, 4'd9: r = 2'd2;
			default:          r = 2'd0;
		endcase
		return r;
	endfunction

	// Node passed over when jumping between two nodes 1..9; zero when none.
	function automatic logic [3:0] middle_node(input logic [3:0] from_n, input logic [3:0] to_n);
		logic [1:0] ax, ay, bx, by, ddx, ddy, mx, my;
		logic [2:0] sx, sy;
		logic [3:0] mid;
		ax  = node_col(from_n);
		ay  = node_row(from_n);
		bx  = node_col(to_n);
		by  = node_row(to_n);
		ddx = (ax > bx) ? (ax - bx) : (bx - ax);
		ddy = (ay > by) ? (ay - by) : (by - ay);
		sx  = {1'b0, ax} + {1'b0, bx};
		sy  = {1'b0, ay} + {1'b0, by};
		mx  = sx[2:1];
		my  = sy[2:1];
		mid = 4'({2'b00, my} * 4'(GRID_SIDE)) + {2'b00, mx} + 4'd1;
		if ((ddx == 2'd2 && ay == by) || (ddy == 2'd2 && ax == bx) ||
			(ddx == 2'd2 && ddy == 2'd2)) begin
			return mid;
		end
		return 4'd0;
	endfunction

endpackage

// ----- rtl/gptr_dist_unit.sv -----
`timescale 1ns / 1ps
// Shared distance unit: difference, squares, then sum and compare against radius squared.
// Three register stages, one node per cycle; uses gptr_pkg.
module gptr_dist_unit #(
	parameter int CW = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic signed [CW-1:0]       px,
	input  logic signed [CW-1:0]       py,
	input  logic signed [CW-1:0]       nx,
	input  logic signed [CW-1:0]       ny,
	input  logic [gptr_pkg::RSQ_W-1:0] rsq,
	output logic                       hit_valid,
	output logic                       hit
);
	import gptr_pkg::*;

	localparam int SQW  = 2 * CW;
	localparam int SUMW = SQW + 1;
	localparam int CMPW = (SUMW > RSQ_W) ? SUMW : RSQ_W;

	logic                  v_s1, v_s2;
	logic signed [CW:0]    dx_s1, dy_s1;
	logic signed [2*CW+1:0] prod_x, prod_y;
	logic [SQW-1:0]        sqx_s2, sqy_s2;
	logic [SUMW-1:0]       sum;

	assign prod_x = dx_s1 * dx_s1;
	assign prod_y = dy_s1 * dy_s1;
	assign sum    = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			hit_valid <= 1'b0;
			dx_s1     <= '0;
			dy_s1     <= '0;
			sqx_s2    <= '0;
			sqy_s2    <= '0;
			hit       <= 1'b0;
		end else begin
			v_s1      <= req_valid;
			v_s2      <= v_s1;
			hit_valid <= v_s2;
			dx_s1     <= {px[CW-1], px} - {nx[CW-1], nx};
			dy_s1     <= {py[CW-1], py} - {ny[CW-1], ny};
			// |d| stays below 2^CW, so the square fits the low 2*CW bits
			sqx_s2    <= prod_x[SQW-1:0];
			sqy_s2    <= prod_y[SQW-1:0];
			hit       <= (CMPW'(sum) <= CMPW'(rsq));
		end
	end

endmodule

// ----- rtl/gptr_seq.sv -----
`timescale 1ns / 1ps
// Sequencer: issues the nine nodes to the distance unit, scans hits in node order,
// inserts skipped middle nodes, keeps the trail state and drives the result word register.
// Uses gptr_pkg.
module gptr_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  gptr_pkg::in_ctl_t in_ctl,
	input  logic              oob,
	output logic              req_valid,
	output logic [3:0]        req_node,
	input  logic              hit_valid,
	input  logic              hit,
	output logic              out_valid,
	input  logic              out_ready,
	output gptr_pkg::res_t    out_res
);
	import gptr_pkg::*;

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	state_t     state_q;
	logic [3:0] issue_q, got_q, scan_q;
	logic [8:0] range_q, mask_q;
	logic [3:0] prev_q, cnt_q;
	logic       stop_q;
	logic       pend_v_q;
	res_t       pend_q;
	logic       out_v_q;
	res_t       out_q;

	logic       out_free, scan_ready, cand, need_mid, can_push, do_rec, finishing, out_load;
	logic [3:0] cur_node, mid, rec_node, cnt_inc;
	res_t       done_res, load_res;

	always_comb begin
		out_free   = !out_v_q || out_ready;
		cur_node   = scan_q + 4'd1;
		scan_ready = (state_q == ST_RUN) && (scan_q < got_q);
		cand       = scan_ready && range_q[scan_q] && !mask_q[scan_q];
		mid        = (prev_q != 4'd0) ? middle_node(prev_q, cur_node) : 4'd0;
		need_mid   = (mid != 4'd0) && !mask_q[mid - 4'd1];
		rec_node   = need_mid ? mid : cur_node;
		cnt_inc    = (cnt_q < 4'(NODE_COUNT)) ? (cnt_q + 4'd1) : cnt_q;
		can_push   = !pend_v_q || out_free;
		do_rec     = cand && can_push;
		finishing  = (state_q == ST_RUN) && (scan_q == 4'(NODE_COUNT)) && out_free;
		out_load   = (do_rec && pend_v_q) || finishing;

		done_res      = pend_q;
		done_res.last = 1'b1;
		if (!pend_v_q) begin
			done_res = '{node: 4'd0, skip: 1'b0, oob: oob, len: cnt_q, last: 1'b1};
		end
		load_res = finishing ? done_res : pend_q;
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign req_valid = (state_q == ST_RUN) && (issue_q < 4'(NODE_COUNT));
	assign req_node  = issue_q;
	assign out_valid = out_v_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issue_q  <= '0;
			got_q    <= '0;
			scan_q   <= '0;
			range_q  <= '0;
			mask_q   <= '0;
			prev_q   <= '0;
			cnt_q    <= '0;
			stop_q   <= 1'b0;
			pend_v_q <= 1'b0;
			pend_q   <= '0;
			out_v_q  <= 1'b0;
			out_q    <= '0;
		end else begin
			out_v_q <= out_load || (out_v_q && !out_ready);
			if (out_load) begin
				out_q <= load_res;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RUN;
						issue_q <= '0;
						got_q   <= '0;
						scan_q  <= '0;
						range_q <= '0;
						stop_q  <= in_ctl.stop;
						if (in_ctl.start) begin
							prev_q <= '0;
							cnt_q  <= '0;
						end
					end
				end
				ST_RUN: begin
					if (req_valid) begin
						issue_q <= issue_q + 4'd1;
					end
					if (hit_valid) begin
						range_q[got_q] <= hit;
						got_q          <= got_q + 4'd1;
					end
					if (do_rec) begin
						// a skipped middle node goes first; hold the scan on the hit node
						mask_q[rec_node - 4'd1] <= 1'b1;
						cnt_q    <= cnt_inc;
						pend_v_q <= 1'b1;
						pend_q   <= '{node: rec_node, skip: need_mid, oob: oob,
							len: cnt_inc, last: 1'b0};
						if (!need_mid) begin
							prev_q <= cur_node;
							scan_q <= scan_q + 4'd1;
						end
					end else if (scan_ready && !cand) begin
						scan_q <= scan_q + 4'd1;
					end
					if (finishing) begin
						state_q  <= ST_IDLE;
						pend_v_q <= 1'b0;
						if (stop_q) begin
							mask_q <= '0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_cnt_sat: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 4'(NODE_COUNT))
		else $error("recorded count above node count");

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_v_q)
		else $error("pending word left behind at idle");

	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> (scan_q <= got_q && got_q <= issue_q))
		else $error("scan ran ahead of distance results");

	a_finish_last: assert property (@(posedge clk) disable iff (!arst_n)
		finishing |=> (out_v_q && out_q.last && state_q == ST_IDLE))
		else $error("finished item did not leave a last word");

endmodule

// ----- rtl/grid_pattern_trail_recognizer.sv -----
`timescale 1ns / 1ps
// Top level of the grid pattern trail recognizer: configuration registers, box test,
// node select and wiring of gptr_dist_unit and gptr_seq; uses gptr_pkg.
//
//  channel | signals                                             | dir
//  --------+-----------------------------------------------------+-----
//  input   | in_valid/in_ready, point_x, point_y, first_point,   | in
//          | final_point                                         |
//  output  | out_valid/out_ready, node_number, via_skip,         | out
//          | out_of_box, pattern_length, last_of_run             |
//  config  | write_en, reg_index, write_data                     | in
//
// A point holds the block after its accept: nine node issues into the three-stage
// distance unit, the scan of the last node and the finishing step; only then is the next
// point accepted. Each inserted middle node is recorded before its hit node, which lengthens the scan.
// A full result word register with out_ready low also holds the scan and the finish.
// in_ready is high only between points; a finished word waits in its own register.
// arst_n clears all registers; the hit mask, last node and count start at zero.
module grid_pattern_trail_recognizer #(
	parameter int COORD_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] point_x,
	input  logic [15:0] point_y,
	input  logic        first_point,
	input  logic        final_point,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  node_number,
	output logic        via_skip,
	output logic        out_of_box,
	output logic [3:0]  pattern_length,
	output logic        last_of_run,
	input  logic        write_en,
	input  logic [2:0]  reg_index,
	input  logic [63:0] write_data
);
	import gptr_pkg::*;

	localparam int CW = COORD_WIDTH;

	logic [63:0]         node_a_q, node_b_q, node_c_q, node_d_q;
	logic [31:0]         node_e_q, box_low_q, box_high_q;
	logic [RADIUS_W-1:0] radius_q;
	logic [RSQ_W-1:0]    rsq_q;

	logic signed [CW-1:0] px, py, blx, bly, bhx, bhy;
	logic signed [CW-1:0] pt_x_q, pt_y_q, nx, ny;
	logic                 oob_c, oob_q, accept;
	logic [31:0]          node_word;

	logic       req_valid, hit_valid, hit;
	logic [3:0] req_node;
	in_ctl_t    in_ctl;
	res_t       res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_a_q   <= '0;
			node_b_q   <= '0;
			node_c_q   <= '0;
			node_d_q   <= '0;
			node_e_q   <= '0;
			radius_q   <= '0;
			box_low_q  <= '0;
			box_high_q <= '0;
		end else if (write_en) begin
			unique case (reg_index)
				REG_NODE_A:   node_a_q   <= write_data;
				REG_NODE_B:   node_b_q   <= write_data;
				REG_NODE_C:   node_c_q   <= write_data;
				REG_NODE_D:   node_d_q   <= write_data;
				REG_NODE_E:   node_e_q   <= write_data[31:0];
				REG_RADIUS:   radius_q   <= write_data[RADIUS_W-1:0];
				REG_BOX_LOW:  box_low_q  <= write_data[31:0];
				REG_BOX_HIGH: box_high_q <= write_data[31:0];
				default:      ;
			endcase
		end
	end

	// radius squared is registered from the radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsq_q <= '0;
		end else begin
			rsq_q <= radius_q * radius_q;
		end
	end

	assign px  = point_x[CW-1:0];
	assign py  = point_y[CW-1:0];
	assign blx = box_low_q[CW-1:0];
	assign bly = box_low_q[HALF_W+CW-1:HALF_W];
	assign bhx = box_high_q[CW-1:0];
	assign bhy = box_high_q[HALF_W+CW-1:HALF_W];
	assign oob_c  = (px < blx) || (px > bhx) || (py < bly) || (py > bhy);
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_x_q <= '0;
			pt_y_q <= '0;
			oob_q  <= 1'b0;
		end else if (accept) begin
			pt_x_q <= px;
			pt_y_q <= py;
			oob_q  <= oob_c;
		end
	end

	always_comb begin
		unique case (req_node)
			4'd0:    node_word = node_a_q[31:0];
			4'd1:    node_word = node_a_q[63:32];
			4'd2:    node_word = node_b_q[31:0];
			4'd3:    node_word = node_b_q[63:32];
			4'd4:    node_word = node_c_q[31:0];
			4'd5:    node_word = node_c_q[63:32];
			4'd6:    node_word = node_d_q[31:0];
			4'd7:    node_word = node_d_q[63:32];
			4'd8:    node_word = node_e_q;
			default: node_word = '0;
		endcase
	end

	assign nx = node_word[CW-1:0];
	assign ny = node_word[HALF_W+CW-1:HALF_W];

	assign in_ctl = '{start: first_point, stop: final_point};

	gptr_dist_unit #(
		.CW(CW)
	) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.px        (pt_x_q),
		.py        (pt_y_q),
		.nx        (nx),
		.ny        (ny),
		.rsq       (rsq_q),
		.hit_valid (hit_valid),
		.hit       (hit)
	);

	gptr_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_ctl    (in_ctl),
		.oob       (oob_q),
		.req_valid (req_valid),
		.req_node  (req_node),
		.hit_valid (hit_valid),
		.hit       (hit),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (res)
	);

	assign node_number    = res.node;
	assign via_skip       = res.skip;
	assign out_of_box     = res.oob;
	assign pattern_length = res.len;
	assign last_of_run    = res.last;

endmodule
